// ===== src/sef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sef_pkg;

  // Fixed field widths
  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 10;
  localparam int GRAD_W  = 12;
  localparam int SQ_W    = 2 * GRAD_W;
  localparam int SQSUM_W = SQ_W + 1;
  localparam int SQRT_W  = 34;
  localparam int ROOT_W  = 17;
  localparam int MAG_W   = 15;
  localparam int CFG_W   = 13;
  localparam int ROW_W   = 12;

  // Image geometry
  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;

  // Integer square root: highest power of four used by the digit recurrence
  localparam logic [SQRT_W-1:0] SQRT_TOP = SQRT_W'(64'h1_0000_0000);

  // floor(n / 3) = (n * ceil(2^19 / 3)) >> 19 for n < 2^19
  localparam int                  DIV3_RECIP_W = 18;
  localparam logic [DIV3_RECIP_W-1:0] DIV3_RECIP = 18'd174763;
  localparam int                  DIV3_SHIFT   = 19;
  localparam int                  PROD_W       = ROOT_W + DIV3_RECIP_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [MAG_W-1:0] edge_magnitude;
    logic             last_result;
  } result_t;

  // Gradient request handed from front to back
  typedef struct packed {
    logic [GRAD_W-1:0] gx_abs;
    logic [GRAD_W-1:0] gy_abs;
    logic              last;
  } grad_t;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic             restart;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/sef_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sef_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/sef_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sef_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sef_pkg::grad_t din,
  output logic               full,
  input  wire logic          pop,
  output sef_pkg::grad_t     dout,
  output logic               empty
);

  localparam int PW = (sef_pkg::QUEUE_DEPTH > 1) ? $clog2(sef_pkg::QUEUE_DEPTH) : 1;

  sef_pkg::grad_t  entry [sef_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (PW+1)'(sef_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry[rd_ptr];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(sef_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== src/sef_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sef_front #(
  parameter int MAX_WIDTH = sef_pkg::MAX_WIDTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sef_pkg::cfg_t   cfg,
  input  wire sef_pkg::pixel_t pixel,
  input  wire logic            push,
  output logic                 full,
  output logic                 q_push,
  output sef_pkg::grad_t       q_item,
  input  wire logic            q_full
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > sef_pkg::CFG_W) ? WW : sef_pkg::CFG_W;
  localparam int SW   = sef_pkg::SUM_W;
  localparam int GW   = sef_pkg::GRAD_W;
  localparam int RW   = sef_pkg::ROW_W;
  localparam int HW   = sef_pkg::CFG_W;

  typedef enum logic [1:0] {
    F_TAKE   = 2'b01,
    F_UPDATE = 2'b10
  } front_state_t;

  front_state_t   state;
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [CW-1:0]  col_next;
  logic [RW-1:0]  row_next;
  logic [SW-1:0]  sum_in;
  logic [SW-1:0]  up_rd;
  logic [SW-1:0]  mid_rd;
  logic [SW-1:0]  win_mid   [3];
  logic [SW-1:0]  win_right [3];
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic           take;
  logic           update;
  logic           last_col;
  logic           last_row;
  logic           interior;
  logic [GW-1:0]  gx_pos, gx_neg, gy_pos, gy_neg;

  // Clamp the programmed size
  always_comb begin
    if (cfg.image_width == '0) begin
      eff_w = WW'(1);
    end else if (CMPW'(cfg.image_width) > CMPW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      eff_h = HW'(1);
    end else if (cfg.image_height > HW'(sef_pkg::HEIGHT_LIMIT)) begin
      eff_h = HW'(sef_pkg::HEIGHT_LIMIT);
    end else begin
      eff_h = cfg.image_height;
    end
  end

  assign take   = (state == F_TAKE) && push && !q_full;
  assign update = (state == F_UPDATE);
  assign full   = (state != F_TAKE) || q_full;

  assign last_col = ((WW'(col) + WW'(1)) == eff_w);
  assign last_row = ((HW'(row) + HW'(1)) == eff_h);
  assign interior = (eff_w >= WW'(3)) && (eff_h >= HW'(3))
                 && (row >= RW'(2)) && (col >= CW'(2));

  always_comb begin
    col_next = col + CW'(1);
    row_next = row;
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row + RW'(1);
    end
  end

  sef_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (update),
    .waddr (col),
    .wdata (mid_rd),
    .raddr (col),
    .rdata (up_rd)
  );

  sef_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (update),
    .waddr (col),
    .wdata (sum_in),
    .raddr (col),
    .rdata (mid_rd)
  );

  // Kernel sums over the window as it stands after this pixel's shift
  always_comb begin
    gx_pos = GW'(up_rd) + GW'({mid_rd, 1'b0}) + GW'(sum_in);
    gx_neg = GW'(win_mid[0]) + GW'({win_mid[1], 1'b0}) + GW'(win_mid[2]);
    gy_pos = GW'(win_mid[2]) + GW'({win_right[2], 1'b0}) + GW'(sum_in);
    gy_neg = GW'(win_mid[0]) + GW'({win_right[0], 1'b0}) + GW'(up_rd);
    q_item.gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    q_item.gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    q_item.last   = last_row && last_col;
  end

  assign q_push = update && interior;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_TAKE;
      col   <= '0;
      row   <= '0;
    end else begin
      unique case (state)
        F_TAKE: begin
          if (take) begin
            state <= F_UPDATE;
          end
        end
        F_UPDATE: begin
          state <= F_TAKE;
        end
        default: begin
          state <= F_TAKE;
        end
      endcase
      // restart the image on any register write
      if (cfg.restart) begin
        col <= '0;
        row <= '0;
      end else if (update) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sum_in <= SW'(pixel.red) + SW'(pixel.green) + SW'(pixel.blue);
    end
    if (update) begin
      win_mid[0]   <= win_right[0];
      win_mid[1]   <= win_right[1];
      win_mid[2]   <= win_right[2];
      win_right[0] <= up_rd;
      win_right[1] <= mid_rd;
      win_right[2] <= sum_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/sef_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sef_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sef_pkg::grad_t  q_item,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output sef_pkg::result_t     result,
  output logic                 empty,
  input  wire logic            pop
);

  localparam int GW = sef_pkg::GRAD_W;
  localparam int QW = sef_pkg::SQRT_W;
  localparam int PW = sef_pkg::PROD_W;

  typedef enum logic [5:0] {
    B_IDLE   = 6'b000001,
    B_SQUARE = 6'b000010,
    B_LOAD   = 6'b000100,
    B_ROOT   = 6'b001000,
    B_SCALE  = 6'b010000,
    B_EMIT   = 6'b100000
  } back_state_t;

  back_state_t                  state;
  logic [GW-1:0]                ux, uy;
  logic                         last;
  logic [sef_pkg::SQ_W-1:0]     sq_x, sq_y;
  logic [sef_pkg::SQSUM_W-1:0]  sq_sum;
  logic [QW-1:0]                rem;
  logic [QW-1:0]                root;
  logic [QW-1:0]                bitv;
  logic [QW-1:0]                trial;
  logic [PW-1:0]                prod;
  logic                         out_valid;
  logic                         emit;

  assign q_pop  = (state == B_IDLE) && !q_empty;
  assign emit   = (state == B_EMIT) && (!out_valid || pop);
  assign empty  = !out_valid;
  assign sq_sum = sef_pkg::SQSUM_W'(sq_x) + sef_pkg::SQSUM_W'(sq_y);
  assign trial  = root + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE:   if (q_pop) state <= B_SQUARE;
        B_SQUARE: state <= B_LOAD;
        B_LOAD:   state <= B_ROOT;
        B_ROOT:   if (bitv[0]) state <= B_SCALE;
        B_SCALE:  state <= B_EMIT;
        B_EMIT:   if (emit) state <= B_IDLE;
        default:  state <= B_IDLE;
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ux   <= q_item.gx_abs;
      uy   <= q_item.gy_abs;
      last <= q_item.last;
    end
    if (state == B_SQUARE) begin
      sq_x <= ux * ux;
      sq_y <= uy * uy;
    end
    if (state == B_LOAD) begin
      rem  <= QW'({sq_sum, 8'b0});
      root <= '0;
      bitv <= sef_pkg::SQRT_TOP;
    end
    // one root digit a cycle
    if (state == B_ROOT) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (state == B_SCALE) begin
      prod <= root[sef_pkg::ROOT_W-1:0] * sef_pkg::DIV3_RECIP;
    end
    if (emit) begin
      result.edge_magnitude <=
        prod[sef_pkg::DIV3_SHIFT + sef_pkg::MAG_W - 1:sef_pkg::DIV3_SHIFT];
      result.last_result <= last;
    end
  end

endmodule

`default_nettype wire

// ===== src/sobel_edge_magnitude_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// pixel     push / full        pixel_t: red, green, blue
// result    empty / pop        result_t: edge_magnitude, last_result
// config    psel/penable/...   image_width (0x0), image_height (0x4)
//
// In the front, a pixel is a line store read, then a window update. An interior
// pixel's magnitude is computed in the back by squaring, the one-digit-a-cycle
// square root (17 steps) and scaling; the 2-entry gradient queue lets
// the front run ahead by two results. rst is synchronous and clears control
// state only; the line stores are not cleared. A result waits in the output
// register until popped, while the front keeps taking pixels until the queue fills.

module sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH = sef_pkg::MAX_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sef_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sef_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sef_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire sef_pkg::pixel_t              pixel,
  input  wire logic                         push,
  output logic                              full,
  output sef_pkg::result_t                  result,
  output logic                              empty,
  input  wire logic                         pop
);

  logic [sef_pkg::CFG_W-1:0] image_width;
  logic [sef_pkg::CFG_W-1:0] image_height;
  logic                      wr_en;
  logic                      reg_sel;
  sef_pkg::cfg_t             cfg;
  sef_pkg::grad_t            q_in;
  sef_pkg::grad_t            q_out;
  logic                      q_push;
  logic                      q_full;
  logic                      q_pop;
  logic                      q_empty;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sef_pkg::WIDTH_RESET;
      image_height <= sef_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        sef_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[sef_pkg::CFG_W-1:0];
        sef_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[sef_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sef_pkg::REG_IMAGE_WIDTH:  prdata = sef_pkg::PDATA_W'(image_width);
      sef_pkg::REG_IMAGE_HEIGHT: prdata = sef_pkg::PDATA_W'(image_height);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.image_width  = image_width;
  assign cfg.image_height = image_height;
  assign cfg.restart      = wr_en;

  sef_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixel  (pixel),
    .push   (push),
    .full   (full),
    .q_push (q_push),
    .q_item (q_in),
    .q_full (q_full)
  );

  sef_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  sef_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_out),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

`default_nettype wire

// ===== src/sef_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sef_checker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             full,
  input  wire sef_pkg::result_t result,
  input  wire logic             empty,
  input  wire logic             pop
);

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // a waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed or dropped before pop");

  // front is busy with the window update right after every accepted pixel
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("pixel accepted on consecutive cycles");

  // magnitude stays within the range of the kernel sums
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.edge_magnitude <= 15'd23080))
    else $error("edge magnitude out of range");

endmodule

bind sobel_edge_magnitude_top sef_checker u_sef_checker (.*);

`default_nettype wire
